/* rtl/core/atbv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package atbv_pkg;
  localparam int AngleBits = 16;
  localparam int FracBits = 14;
  localparam int TrigIterations = 16;
  localparam int WorkFrac = 30;
  localparam int DataW = 16;
  localparam int WW = 34;
  localparam int PW = 64;
  localparam logic signed [WW-1:0] GainQ30 = 34'sd652032874;

  typedef logic signed [WW-1:0] work_t;

  typedef struct packed {
    logic signed [DataW-1:0] pitch;
    logic signed [DataW-1:0] yaw;
    logic signed [DataW-1:0] roll;
  } angles_t;

  typedef struct packed {
    logic signed [DataW-1:0] forward_x;
    logic signed [DataW-1:0] forward_y;
    logic signed [DataW-1:0] forward_z;
    logic signed [DataW-1:0] right_x;
    logic signed [DataW-1:0] right_y;
    logic signed [DataW-1:0] right_z;
    logic signed [DataW-1:0] up_x;
    logic signed [DataW-1:0] up_y;
    logic signed [DataW-1:0] up_z;
  } basis_t;

  typedef struct packed {
    work_t s;
    work_t c;
  } sincos_t;

  function automatic work_t atan_lut(input int i);
    logic [31:0] a;
    case (i)
      0: a = 32'h20000000;  1: a = 32'h12E4051D;  2: a = 32'h09FB385B;
      3: a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
      6: a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
      9: a = 32'h00145F2E;  10: a = 32'h000A2F98; 11: a = 32'h000517CC;
      12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2F9;
      15: a = 32'h0000517C; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
      18: a = 32'h00000A2F; 19: a = 32'h00000517; 20: a = 32'h0000028B;
      21: a = 32'h00000145; 22: a = 32'h000000A2; 23: a = 32'h00000051;
      24: a = 32'h00000028; 25: a = 32'h00000014; 26: a = 32'h0000000A;
      27: a = 32'h00000005; 28: a = 32'h00000002; 29: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return work_t'({2'b00, a});
  endfunction

  // Q30 x Q30 -> Q30, round half up
  function automatic work_t mulq(input work_t a, input work_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) <<< (WorkFrac - 1));
    return work_t'(p >>> WorkFrac);
  endfunction

  function automatic logic signed [DataW-1:0] to_out(input work_t v);
    work_t r;
    work_t lim;
    lim = work_t'(1) <<< FracBits;
    r = (v + (work_t'(1) <<< (WorkFrac - FracBits - 1))) >>> (WorkFrac - FracBits);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[DataW-1:0];
  endfunction
endpackage
`default_nettype wire

/* rtl/core/atbv_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface atbv_stream_if #(parameter type payload_t = logic) (input wire logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/atbv_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// One CORDIC step per pipeline stage; fold on entry, sign fix on exit.
module atbv_cordic import atbv_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [DataW-1:0] angle,
  output sincos_t result
);
  work_t x [TrigIterations+1];
  work_t y [TrigIterations+1];
  work_t z [TrigIterations+1];
  logic  flip [TrigIterations+1];
  work_t z0;
  logic [31:0] u;

  always_comb begin
    u = {angle[AngleBits-1:0], {(32-AngleBits){1'b0}}};
    z0 = work_t'($signed(u));
  end

  // outside a quarter turn: move by half a turn, negate at the end
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= GainQ30;
      y[0] <= '0;
      if (z0 > work_t'(32'sh40000000) || z0 < -work_t'(32'sh40000000)) begin
        z[0] <= (z0[WW-1]) ? z0 + work_t'(34'sh080000000) : z0 - work_t'(34'sh080000000);
        flip[0] <= 1'b1;
      end else begin
        z[0] <= z0;
        flip[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < TrigIterations; i++) begin : g_step
    localparam int Sh = (i < 32) ? i : 31;
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z[i][WW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> Sh);
          y[i+1] <= y[i] + (x[i] >>> Sh);
          z[i+1] <= z[i] - atan_lut(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> Sh);
          y[i+1] <= y[i] - (x[i] >>> Sh);
          z[i+1] <= z[i] + atan_lut(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.s <= flip[TrigIterations] ? -y[TrigIterations] : y[TrigIterations];
      result.c <= flip[TrigIterations] ? -x[TrigIterations] : x[TrigIterations];
    end
  end
endmodule
`default_nettype wire

/* rtl/core/atbv_combine.sv */
`timescale 1ns / 1ps
`default_nettype none
// Three registered product/sum stages.
module atbv_combine import atbv_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  sincos_t p,
  input  sincos_t yw,
  input  sincos_t r,
  output basis_t  vec
);
  work_t cpcy, cpsy, nsp, crsy, crcy, srcp, srsy, srcy, crcp, srsp, crsp;
  work_t cy1, sy1;
  work_t fx, fy, fz, rx, ry, rz, ux, uy, uz;

  always_ff @(posedge clk) begin
    if (en) begin
      cpcy <= mulq(p.c, yw.c);
      cpsy <= mulq(p.c, yw.s);
      nsp  <= -p.s;
      crsy <= mulq(r.c, yw.s);
      crcy <= mulq(r.c, yw.c);
      srcp <= -mulq(r.s, p.c);
      srsy <= mulq(r.s, yw.s);
      srcy <= mulq(r.s, yw.c);
      crcp <= mulq(r.c, p.c);
      srsp <= mulq(r.s, p.s);
      crsp <= mulq(r.c, p.s);
      cy1  <= yw.c;
      sy1  <= yw.s;
      fx <= cpcy; fy <= cpsy; fz <= nsp; rz <= srcp; uz <= crcp;
      rx <= crsy - mulq(srsp, cy1);
      ry <= -mulq(srsp, sy1) - crcy;
      ux <= mulq(crsp, cy1) + srsy;
      uy <= mulq(crsp, sy1) - srcy;
      vec.forward_x <= to_out(fx);
      vec.forward_y <= to_out(fy);
      vec.forward_z <= to_out(fz);
      vec.right_x <= to_out(rx);
      vec.right_y <= to_out(ry);
      vec.right_z <= to_out(rz);
      vec.up_x <= to_out(ux);
      vec.up_y <= to_out(uy);
      vec.up_z <= to_out(uz);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/angles_to_basis_vectors_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: fold, 16 CORDIC steps, sign fix, 3 combine stages.
// Throughput: one item per cycle; the whole pipe advances when the output slot is free.
// Reset: synchronous, active high; clears only the valid bits, data regs are not reset.
// Stall: the pipeline freezes while the output item is held and not taken.
module angles_to_basis_vectors_top import atbv_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  atbv_stream_if.sink   in_ch,
  atbv_stream_if.source out_ch
);
  localparam int Lat = TrigIterations + 5;
  logic [Lat-1:0] vld;
  logic en;
  sincos_t sp, sy, sr;
  basis_t vec;
  angles_t a;

  // advance when the last slot is empty or being taken
  assign en = !vld[Lat-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign a = in_ch.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_ch.valid};
    end
  end

  atbv_cordic u_p (.clk(clk), .en(en), .angle(a.pitch), .result(sp));
  atbv_cordic u_y (.clk(clk), .en(en), .angle(a.yaw),   .result(sy));
  atbv_cordic u_r (.clk(clk), .en(en), .angle(a.roll),  .result(sr));

  atbv_combine u_comb (.clk(clk), .en(en), .p(sp), .yw(sy), .r(sr), .vec(vec));

  assign out_ch.valid = vld[Lat-1];
  assign out_ch.data = vec;
endmodule
`default_nettype wire
